@@ rtl/qtrwa_pkg.sv @@
// shared types, constants and helpers for the quad to rect warp address block
package qtrwa_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int FRAC_BITS  = 16;
    localparam int CORNER_FRAC = 8;
    localparam int EDGE_SHIFT = FRAC_BITS - CORNER_FRAC;

    localparam int DIM_W      = $clog2(MAX_DIM) + 1;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int ACC_W      = 32;
    localparam int CORNER_W   = 64;
    localparam int INT_W      = ACC_W - FRAC_BITS;
    localparam int NUM_W      = ACC_W + 1 + EDGE_SHIFT;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_LEFT     = 3'd0,
        CFG_TOP_RIGHT    = 3'd1,
        CFG_BOTTOM_RIGHT = 3'd2,
        CFG_BOTTOM_LEFT  = 3'd3,
        CFG_OUT_WIDTH    = 3'd4,
        CFG_OUT_HEIGHT   = 3'd5,
        CFG_SCENE_WIDTH  = 3'd6,
        CFG_SCENE_HEIGHT = 3'd7
    } cfg_index_t;

    // one classified pixel request, passed from front to back
    typedef struct packed {
        logic             start;
        logic             col0;
        logic             row_end;
        logic             done;
        logic [CNT_W-1:0] out_x;
        logic [CNT_W-1:0] out_y;
    } item_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(2))
        begin
            r = DIM_W'(2);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

@@ rtl/qtrwa_front.sv @@
// front end: accepts pixel requests, runs the raster counters and classifies each pixel
module qtrwa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           frame_start,
    input  logic [qtrwa_pkg::DIM_W-1:0]    out_width,
    input  logic [qtrwa_pkg::DIM_W-1:0]    out_height,
    input  logic                           q_ready,
    output logic                           push,
    output qtrwa_pkg::item_t               item
);

    logic [qtrwa_pkg::CNT_W-1:0] col_reg, col_next;
    logic [qtrwa_pkg::CNT_W-1:0] row_reg, row_next;
    logic [qtrwa_pkg::DIM_W-1:0] w, h;
    logic                        start;
    logic [qtrwa_pkg::CNT_W-1:0] col_a, row_a, col_b, row_b;
    logic                        row_end, last_row;

    assign w = qtrwa_pkg::clamp_dim(out_width);
    assign h = qtrwa_pkg::clamp_dim(out_height);

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    always_comb
    begin
        start    = frame_start || (col_reg == '0 && row_reg == '0);
        col_a    = start ? '0 : col_reg;
        row_a    = start ? '0 : row_reg;
        // counters left over from a larger frame size wrap to zero
        col_b    = ({1'b0, col_a} >= w) ? '0 : col_a;
        row_b    = ({1'b0, row_a} >= h) ? '0 : row_a;
        row_end  = ({1'b0, col_b} + qtrwa_pkg::DIM_W'(1)) == w;
        last_row = ({1'b0, row_b} + qtrwa_pkg::DIM_W'(1)) == h;

        item.start   = start;
        item.col0    = (col_b == '0);
        item.row_end = row_end;
        item.done    = row_end && last_row;
        item.out_x   = col_b;
        item.out_y   = row_b;

        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_b + qtrwa_pkg::CNT_W'(1);
            end
            else
            begin
                col_next = col_b + qtrwa_pkg::CNT_W'(1);
                row_next = row_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/qtrwa_queue.sv @@
// short request queue between front and back
module qtrwa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qtrwa_pkg::item_t push_item,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output qtrwa_pkg::item_t pop_item
);

    qtrwa_pkg::item_t                 slot_reg [qtrwa_pkg::QUEUE_DEPTH];
    logic [qtrwa_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [qtrwa_pkg::QPTR_W:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign not_full  = count_reg != (qtrwa_pkg::QPTR_W+1)'(qtrwa_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (qtrwa_pkg::QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (qtrwa_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + qtrwa_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + qtrwa_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/qtrwa_div.sv @@
// serial signed divider, one quotient bit per cycle, truncates toward zero
module qtrwa_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [qtrwa_pkg::NUM_W-1:0] num,
    input  logic [qtrwa_pkg::CNT_W-1:0]       den,
    output logic                              done,
    output logic [qtrwa_pkg::ACC_W-1:0]       quot
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [qtrwa_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                               neg_reg;
    logic [qtrwa_pkg::NUM_W-1:0]        dvd_reg, dvd_next;
    logic [qtrwa_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic [qtrwa_pkg::CNT_W:0]          rem_sh;
    logic                               ge;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[qtrwa_pkg::NUM_W-1]};
        ge       = rem_sh >= {1'b0, den};
        rem_next = ge ? qtrwa_pkg::CNT_W'(rem_sh - {1'b0, den})
                      : rem_sh[qtrwa_pkg::CNT_W-1:0];
        dvd_next = {dvd_reg[qtrwa_pkg::NUM_W-2:0], ge};
    end

    assign done = done_reg;
    assign quot = neg_reg ? -dvd_reg[qtrwa_pkg::ACC_W-1:0] : dvd_reg[qtrwa_pkg::ACC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= qtrwa_pkg::DIV_CNT_W'(qtrwa_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - qtrwa_pkg::DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[qtrwa_pkg::NUM_W-1];
            dvd_reg <= num[qtrwa_pkg::NUM_W-1] ? -num : num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

endmodule

@@ rtl/qtrwa_back.sv @@
// back end: edge and position accumulators, step divisions and address output
module qtrwa_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  qtrwa_pkg::item_t                   q_item,
    output logic                               q_pop,
    input  logic [qtrwa_pkg::CORNER_W-1:0]     corner_tl,
    input  logic [qtrwa_pkg::CORNER_W-1:0]     corner_tr,
    input  logic [qtrwa_pkg::CORNER_W-1:0]     corner_br,
    input  logic [qtrwa_pkg::CORNER_W-1:0]     corner_bl,
    input  logic [qtrwa_pkg::DIM_W-1:0]        out_width,
    input  logic [qtrwa_pkg::DIM_W-1:0]        out_height,
    input  logic [qtrwa_pkg::DIM_W-1:0]        scene_width,
    input  logic [qtrwa_pkg::DIM_W-1:0]        scene_height,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [qtrwa_pkg::CNT_W-1:0]        out_x,
    output logic [qtrwa_pkg::CNT_W-1:0]        out_y,
    output logic [qtrwa_pkg::CNT_W-1:0]        src_x,
    output logic [qtrwa_pkg::CNT_W-1:0]        src_y,
    output logic                               inside_res,
    output logic                               frame_done
);

    localparam int AW = qtrwa_pkg::ACC_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LAUNCH = 4'b0010,
        S_WAIT   = 4'b0100,
        S_EMIT   = 4'b1000
    } back_state_t;

    typedef enum logic [2:0] {
        JOB_LEFT_X  = 3'd0,
        JOB_LEFT_Y  = 3'd1,
        JOB_RIGHT_X = 3'd2,
        JOB_RIGHT_Y = 3'd3,
        JOB_ROW_X   = 3'd4,
        JOB_ROW_Y   = 3'd5
    } job_t;

    function automatic logic [AW-1:0] corner_to_acc(input logic [AW-1:0] c);
        return {c[AW-1-qtrwa_pkg::EDGE_SHIFT:0], {qtrwa_pkg::EDGE_SHIFT{1'b0}}};
    endfunction

    back_state_t        state_reg, state_next;
    job_t               job_reg, job_next;
    qtrwa_pkg::item_t   cur_reg;

    logic [AW-1:0] left_x_reg, left_y_reg, right_x_reg, right_y_reg;
    logic [AW-1:0] step_reg [4];
    logic [AW-1:0] pos_x_reg, pos_y_reg, rstep_x_reg, rstep_y_reg;

    logic                               out_valid_reg;
    logic [qtrwa_pkg::CNT_W-1:0]        out_x_reg, out_y_reg, src_x_reg, src_y_reg;
    logic                               inside_reg, done_reg;

    logic [qtrwa_pkg::DIM_W-1:0]        w, h;
    logic [qtrwa_pkg::CNT_W-1:0]        w_m1, h_m1;
    logic                               div_start, div_done;
    logic signed [qtrwa_pkg::NUM_W-1:0] div_num;
    logic [qtrwa_pkg::CNT_W-1:0]        div_den;
    logic [AW-1:0]                      div_quot;
    logic [AW-1:0]                      top_sel, bot_sel;
    logic signed [AW:0]                 diff;

    logic                               out_free, emit_fire;
    logic [AW-1:0]                      mag_x, mag_y;
    logic [qtrwa_pkg::INT_W-1:0]        int_x, int_y;
    logic                               in_x, in_y, in_scene;

    assign w    = qtrwa_pkg::clamp_dim(out_width);
    assign h    = qtrwa_pkg::clamp_dim(out_height);
    assign w_m1 = qtrwa_pkg::CNT_W'(w - qtrwa_pkg::DIM_W'(1));
    assign h_m1 = qtrwa_pkg::CNT_W'(h - qtrwa_pkg::DIM_W'(1));

    // numerator and divisor for the current step division
    always_comb
    begin
        case (job_reg)
            JOB_LEFT_X:
            begin
                top_sel = corner_tl[AW-1:0];
                bot_sel = corner_bl[AW-1:0];
            end
            JOB_LEFT_Y:
            begin
                top_sel = corner_tl[2*AW-1:AW];
                bot_sel = corner_bl[2*AW-1:AW];
            end
            JOB_RIGHT_X:
            begin
                top_sel = corner_tr[AW-1:0];
                bot_sel = corner_br[AW-1:0];
            end
            JOB_RIGHT_Y:
            begin
                top_sel = corner_tr[2*AW-1:AW];
                bot_sel = corner_br[2*AW-1:AW];
            end
            JOB_ROW_X:
            begin
                top_sel = left_x_reg;
                bot_sel = right_x_reg;
            end
            JOB_ROW_Y:
            begin
                top_sel = left_y_reg;
                bot_sel = right_y_reg;
            end
            default:
            begin
                top_sel = '0;
                bot_sel = '0;
            end
        endcase
        diff = $signed({bot_sel[AW-1], bot_sel}) - $signed({top_sel[AW-1], top_sel});
        if (job_reg == JOB_ROW_X || job_reg == JOB_ROW_Y)
        begin
            div_num = {{qtrwa_pkg::EDGE_SHIFT{diff[AW]}}, diff};
            div_den = w_m1;
        end
        else
        begin
            div_num = {diff, {qtrwa_pkg::EDGE_SHIFT{1'b0}}};
            div_den = h_m1;
        end
    end

    assign div_start = (state_reg == S_LAUNCH);

    qtrwa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // truncation toward zero: a position in (-1, 0) gives address 0
    always_comb
    begin
        mag_x    = pos_x_reg[AW-1] ? -pos_x_reg : pos_x_reg;
        mag_y    = pos_y_reg[AW-1] ? -pos_y_reg : pos_y_reg;
        int_x    = mag_x[AW-1:qtrwa_pkg::FRAC_BITS];
        int_y    = mag_y[AW-1:qtrwa_pkg::FRAC_BITS];
        in_x     = (!pos_x_reg[AW-1] || int_x == '0) && (AW'(int_x) < AW'(scene_width));
        in_y     = (!pos_y_reg[AW-1] || int_y == '0) && (AW'(int_y) < AW'(scene_height));
        in_scene = in_x && in_y;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.start)
                    begin
                        job_next   = JOB_LEFT_X;
                        state_next = S_LAUNCH;
                    end
                    else if (q_item.col0)
                    begin
                        job_next   = JOB_ROW_X;
                        state_next = S_LAUNCH;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (job_reg == JOB_ROW_Y)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        job_next   = job_t'(job_reg + 3'd1);
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_LEFT_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
            if (q_item.start)
            begin
                left_x_reg  <= corner_to_acc(corner_tl[AW-1:0]);
                left_y_reg  <= corner_to_acc(corner_tl[2*AW-1:AW]);
                right_x_reg <= corner_to_acc(corner_tr[AW-1:0]);
                right_y_reg <= corner_to_acc(corner_tr[2*AW-1:AW]);
            end
        end
        if (state_reg == S_WAIT && div_done)
        begin
            case (job_reg)
                JOB_LEFT_X:  step_reg[0] <= div_quot;
                JOB_LEFT_Y:  step_reg[1] <= div_quot;
                JOB_RIGHT_X: step_reg[2] <= div_quot;
                JOB_RIGHT_Y: step_reg[3] <= div_quot;
                JOB_ROW_X:   rstep_x_reg <= div_quot;
                JOB_ROW_Y:
                begin
                    rstep_y_reg <= div_quot;
                    pos_x_reg   <= left_x_reg;
                    pos_y_reg   <= left_y_reg;
                end
                default:
                begin
                end
            endcase
        end
        if (emit_fire)
        begin
            out_x_reg  <= cur_reg.out_x;
            out_y_reg  <= cur_reg.out_y;
            src_x_reg  <= in_scene ? qtrwa_pkg::CNT_W'(int_x) : '0;
            src_y_reg  <= in_scene ? qtrwa_pkg::CNT_W'(int_y) : '0;
            inside_reg <= in_scene;
            done_reg   <= cur_reg.done;
            pos_x_reg  <= pos_x_reg + rstep_x_reg;
            pos_y_reg  <= pos_y_reg + rstep_y_reg;
            if (cur_reg.row_end)
            begin
                left_x_reg  <= left_x_reg + step_reg[0];
                left_y_reg  <= left_y_reg + step_reg[1];
                right_x_reg <= right_x_reg + step_reg[2];
                right_y_reg <= right_y_reg + step_reg[3];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign inside_res = inside_reg;
    assign frame_done = done_reg;

    // a quotient only ever arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_WAIT)
        else $error("divider finished outside of wait state");

    // the row steps are the last division before a pixel is emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && state_next == S_EMIT) |-> job_reg == JOB_ROW_Y)
        else $error("emit entered before row steps were ready");

    // a new result only appears after an emit cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result appeared without emit");

    // a frame start always begins a row
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.start) |-> q_item.col0)
        else $error("frame start request not classified as row begin");

endmodule

@@ rtl/quad_to_rect_warp_address.sv @@
// top level: configuration registers, front end, request queue and back end
//
// Usage:
//   Input channel in_valid / in_ready carries one request per output pixel in
//   raster order; frame_start = 1 forces a new frame. Output channel
//   out_valid / out_ready carries one result per request: out_x, out_y,
//   src_x, src_y, inside_res and frame_done.
//   Configuration is written through cfg_we / cfg_index / cfg_data with no
//   wait; the user must see that it is written only while no request is in
//   flight, which the block does not enforce. Corners take effect at the
//   next frame start. A request passes through the queue, the back end's
//   idle and emit states and the output register. The first pixel of a row
//   adds two step divisions; the first pixel of a frame adds six. The
//   divisions run on one shared serial divider that yields one quotient bit
//   per cycle over a 41-bit numerator.
//   A two-entry request queue lets the front keep accepting while the back
//   divides or while the output register waits on a stalled receiver.
//   Reset clears the raster counters, the queue and the output valid; the
//   registers return to zero corners, a 2 x 2 output and a 1 x 1 scene.
module quad_to_rect_warp_address (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                frame_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [qtrwa_pkg::CNT_W-1:0]         out_x,
    output logic [qtrwa_pkg::CNT_W-1:0]         out_y,
    output logic [qtrwa_pkg::CNT_W-1:0]         src_x,
    output logic [qtrwa_pkg::CNT_W-1:0]         src_y,
    output logic                                inside_res,
    output logic                                frame_done,
    input  logic                                cfg_we,
    input  logic [qtrwa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qtrwa_pkg::CORNER_W-1:0]      cfg_data
);

    logic [qtrwa_pkg::CORNER_W-1:0] corner_tl_reg, corner_tr_reg;
    logic [qtrwa_pkg::CORNER_W-1:0] corner_br_reg, corner_bl_reg;
    logic [qtrwa_pkg::DIM_W-1:0]    out_width_reg, out_height_reg;
    logic [qtrwa_pkg::DIM_W-1:0]    scene_width_reg, scene_height_reg;

    logic             q_ready, q_push, q_valid, q_pop;
    qtrwa_pkg::item_t push_item, pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_tl_reg    <= '0;
            corner_tr_reg    <= '0;
            corner_br_reg    <= '0;
            corner_bl_reg    <= '0;
            out_width_reg    <= qtrwa_pkg::DIM_W'(2);
            out_height_reg   <= qtrwa_pkg::DIM_W'(2);
            scene_width_reg  <= qtrwa_pkg::DIM_W'(1);
            scene_height_reg <= qtrwa_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (qtrwa_pkg::cfg_index_t'(cfg_index))
                qtrwa_pkg::CFG_TOP_LEFT:     corner_tl_reg    <= cfg_data;
                qtrwa_pkg::CFG_TOP_RIGHT:    corner_tr_reg    <= cfg_data;
                qtrwa_pkg::CFG_BOTTOM_RIGHT: corner_br_reg    <= cfg_data;
                qtrwa_pkg::CFG_BOTTOM_LEFT:  corner_bl_reg    <= cfg_data;
                qtrwa_pkg::CFG_OUT_WIDTH:    out_width_reg    <= cfg_data[qtrwa_pkg::DIM_W-1:0];
                qtrwa_pkg::CFG_OUT_HEIGHT:   out_height_reg   <= cfg_data[qtrwa_pkg::DIM_W-1:0];
                qtrwa_pkg::CFG_SCENE_WIDTH:  scene_width_reg  <= cfg_data[qtrwa_pkg::DIM_W-1:0];
                qtrwa_pkg::CFG_SCENE_HEIGHT: scene_height_reg <= cfg_data[qtrwa_pkg::DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    qtrwa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_start (frame_start),
        .out_width   (out_width_reg),
        .out_height  (out_height_reg),
        .q_ready     (q_ready),
        .push        (q_push),
        .item        (push_item)
    );

    qtrwa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    qtrwa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .corner_tl    (corner_tl_reg),
        .corner_tr    (corner_tr_reg),
        .corner_br    (corner_br_reg),
        .corner_bl    (corner_bl_reg),
        .out_width    (out_width_reg),
        .out_height   (out_height_reg),
        .scene_width  (scene_width_reg),
        .scene_height (scene_height_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .src_x        (src_x),
        .src_y        (src_y),
        .inside_res   (inside_res),
        .frame_done   (frame_done)
    );

endmodule

@@ dv/warp_address_checker.sv @@
// checker for the warp address block: watches both channels and the register port
`timescale 1ns / 1ps

module warp_address_checker
    import qtrwa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 frame_start,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CNT_W-1:0]     out_x,
    input  logic [CNT_W-1:0]     out_y,
    input  logic [CNT_W-1:0]     src_x,
    input  logic [CNT_W-1:0]     src_y,
    input  logic                 inside_res,
    input  logic                 frame_done,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CORNER_W-1:0]  cfg_data,
    input  logic                 drain_done,
    output int                   fail_count
);

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] sx;
        logic [CNT_W-1:0] sy;
        logic             in_scene;
        logic             last_px;
    } pixel_addr_t;

    // shadow of the register file
    logic [CORNER_W-1:0] corner_tl = '0;
    logic [CORNER_W-1:0] corner_tr = '0;
    logic [CORNER_W-1:0] corner_br = '0;
    logic [CORNER_W-1:0] corner_bl = '0;
    logic [DIM_W-1:0]    width_reg = DIM_W'(2);
    logic [DIM_W-1:0]    height_reg = DIM_W'(2);
    logic [DIM_W-1:0]    scene_w_reg = DIM_W'(1);
    logic [DIM_W-1:0]    scene_h_reg = DIM_W'(1);

    // raster walk state
    logic [ACC_W-1:0] left_x = '0, left_y = '0, right_x = '0, right_y = '0;
    logic [ACC_W-1:0] step_lx = '0, step_ly = '0, step_rx = '0, step_ry = '0;
    logic [ACC_W-1:0] walk_x = '0, walk_y = '0, walk_dx = '0, walk_dy = '0;
    int unsigned      col_cnt = 0, row_cnt = 0;

    pixel_addr_t expected_addr_q[$];
    pixel_addr_t next_px, want_px;
    logic        drain_checked = 1'b0;

    function automatic int unsigned clip_size(input logic [DIM_W-1:0] v);
        if (v < DIM_W'(2))
        begin
            return 2;
        end
        if (v > DIM_W'(MAX_DIM))
        begin
            return MAX_DIM;
        end
        return 32'(v);
    endfunction

    function automatic logic [ACC_W-1:0] to_acc(input logic [ACC_W-1:0] c);
        return c << EDGE_SHIFT;
    endfunction

    // exact difference, optionally scaled, divided with truncation toward zero
    function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] from_v,
                                                  input logic [ACC_W-1:0] to_v,
                                                  input int shift,
                                                  input int unsigned n);
        longint num;
        longint q;
        num = (longint'($signed(to_v)) - longint'($signed(from_v))) * (longint'(1) << shift);
        q = num / longint'(n - 1);
        return q[ACC_W-1:0];
    endfunction

    function automatic longint whole_part(input logic [ACC_W-1:0] acc);
        longint p;
        p = longint'($signed(acc));
        if (p >= 0)
        begin
            return p >>> FRAC_BITS;
        end
        return -((-p) >>> FRAC_BITS);
    endfunction

    task automatic advance_raster(input logic fs, output pixel_addr_t px);
        int unsigned w;
        int unsigned h;
        longint      ix;
        longint      iy;
        logic        hit;
        w = clip_size(width_reg);
        h = clip_size(height_reg);
        if (fs || (col_cnt == 0 && row_cnt == 0))
        begin
            col_cnt = 0;
            row_cnt = 0;
            left_x  = to_acc(corner_tl[31:0]);
            left_y  = to_acc(corner_tl[63:32]);
            right_x = to_acc(corner_tr[31:0]);
            right_y = to_acc(corner_tr[63:32]);
            step_lx = div_step(corner_tl[31:0], corner_bl[31:0], EDGE_SHIFT, h);
            step_ly = div_step(corner_tl[63:32], corner_bl[63:32], EDGE_SHIFT, h);
            step_rx = div_step(corner_tr[31:0], corner_br[31:0], EDGE_SHIFT, h);
            step_ry = div_step(corner_tr[63:32], corner_br[63:32], EDGE_SHIFT, h);
        end
        if (col_cnt >= w)
        begin
            col_cnt = 0;
        end
        if (row_cnt >= h)
        begin
            row_cnt = 0;
        end
        if (col_cnt == 0)
        begin
            walk_x  = left_x;
            walk_y  = left_y;
            walk_dx = div_step(left_x, right_x, 0, w);
            walk_dy = div_step(left_y, right_y, 0, w);
        end
        ix  = whole_part(walk_x);
        iy  = whole_part(walk_y);
        hit = ix >= 0 && ix < longint'(scene_w_reg) && iy >= 0 && iy < longint'(scene_h_reg);
        px.col      = col_cnt[CNT_W-1:0];
        px.row      = row_cnt[CNT_W-1:0];
        px.sx       = hit ? ix[CNT_W-1:0] : '0;
        px.sy       = hit ? iy[CNT_W-1:0] : '0;
        px.in_scene = hit;
        px.last_px  = (col_cnt + 1 == w) && (row_cnt + 1 == h);
        walk_x  = walk_x + walk_dx;
        walk_y  = walk_y + walk_dy;
        col_cnt = col_cnt + 1;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            left_x  = left_x + step_lx;
            left_y  = left_y + step_ly;
            right_x = right_x + step_rx;
            right_y = right_y + step_ry;
            row_cnt = row_cnt + 1;
            if (row_cnt >= h)
            begin
                row_cnt = 0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_tl   = '0;
            corner_tr   = '0;
            corner_br   = '0;
            corner_bl   = '0;
            width_reg   = DIM_W'(2);
            height_reg  = DIM_W'(2);
            scene_w_reg = DIM_W'(1);
            scene_h_reg = DIM_W'(1);
            left_x = '0; left_y = '0; right_x = '0; right_y = '0;
            step_lx = '0; step_ly = '0; step_rx = '0; step_ry = '0;
            walk_x = '0; walk_y = '0; walk_dx = '0; walk_dy = '0;
            col_cnt = 0;
            row_cnt = 0;
            expected_addr_q.delete();
            fail_count = 0;
            drain_checked = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TOP_LEFT:     corner_tl = cfg_data;
                    CFG_TOP_RIGHT:    corner_tr = cfg_data;
                    CFG_BOTTOM_RIGHT: corner_br = cfg_data;
                    CFG_BOTTOM_LEFT:  corner_bl = cfg_data;
                    CFG_OUT_WIDTH:    width_reg = cfg_data[DIM_W-1:0];
                    CFG_OUT_HEIGHT:   height_reg = cfg_data[DIM_W-1:0];
                    CFG_SCENE_WIDTH:  scene_w_reg = cfg_data[DIM_W-1:0];
                    CFG_SCENE_HEIGHT: scene_h_reg = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                advance_raster(frame_start, next_px);
                expected_addr_q = {expected_addr_q, next_px};
            end
            if (out_valid && out_ready)
            begin
                if (expected_addr_q.size() == 0)
                begin
                    $error("result with no request waiting: out_x %0d out_y %0d",
                           out_x, out_y);
                    fail_count++;
                end
                else
                begin
                    want_px = expected_addr_q.pop_front();
                    check_field("out_x", want_px.col, out_x);
                    check_field("out_y", want_px.row, out_y);
                    check_field("src_x", want_px.sx, src_x);
                    check_field("src_y", want_px.sy, src_y);
                    check_field("inside_res", CNT_W'(want_px.in_scene), CNT_W'(inside_res));
                    check_field("frame_done", CNT_W'(want_px.last_px), CNT_W'(frame_done));
                end
            end
            if (drain_done && !drain_checked)
            begin
                drain_checked = 1'b1;
                if (expected_addr_q.size() != 0)
                begin
                    $error("%0d results never arrived", expected_addr_q.size());
                    fail_count += expected_addr_q.size();
                end
            end
        end
    end

endmodule

@@ dv/tb_quad_to_rect_warp_address.sv @@
// testbench top for the warp address block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_quad_to_rect_warp_address;

    import qtrwa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_ITEMS   = 1000;

    typedef logic [CORNER_W-1:0] reg_image_t [8];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 frame_start = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CORNER_W-1:0]  cfg_data = '0;
    logic                 drain_done = 1'b0;

    logic                 in_ready;
    logic                 out_valid;
    logic [CNT_W-1:0]     out_x;
    logic [CNT_W-1:0]     out_y;
    logic [CNT_W-1:0]     src_x;
    logic [CNT_W-1:0]     src_y;
    logic                 inside_res;
    logic                 frame_done;

    int fail_count;
    int requests_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int ready_run = 0;

    quad_to_rect_warp_address DUT (.*);

    warp_address_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: ready runs of random length, broken by short stalls
    always @(posedge clk)
    begin
        if (ready_run > 0)
        begin
            ready_run--;
        end
        else if (out_ready)
        begin
            out_ready <= 1'b0;
            ready_run = $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b1;
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 20);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [CORNER_W-1:0] corner(input logic [31:0] x, input logic [31:0] y);
        return {y, x};
    endfunction

    function automatic reg_image_t pack_setting(input logic [CORNER_W-1:0] tl, tr, br, bl,
                                                input int unsigned ow, oh, sw, sh);
        reg_image_t r;
        r[CFG_TOP_LEFT]     = tl;
        r[CFG_TOP_RIGHT]    = tr;
        r[CFG_BOTTOM_RIGHT] = br;
        r[CFG_BOTTOM_LEFT]  = bl;
        r[CFG_OUT_WIDTH]    = CORNER_W'(ow);
        r[CFG_OUT_HEIGHT]   = CORNER_W'(oh);
        r[CFG_SCENE_WIDTH]  = CORNER_W'(sw);
        r[CFG_SCENE_HEIGHT] = CORNER_W'(sh);
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] rand_out_dim();
        case ($urandom_range(0, 11))
            0:       return DIM_W'(0);
            1:       return DIM_W'(1);
            2:       return DIM_W'(MAX_DIM);
            3:       return '1;
            default: return DIM_W'($urandom_range(2, 9));
        endcase
    endfunction

    // size registers keep only their low bits, so junk above them is fair game
    function automatic logic [CORNER_W-1:0] pad_size(input logic [DIM_W-1:0] v);
        logic [CORNER_W-1:0] d;
        d = '0;
        if ($urandom_range(0, 1) == 1)
        begin
            d = {$urandom, $urandom};
        end
        d[DIM_W-1:0] = v;
        return d;
    endfunction

    function automatic logic [31:0] rand_coord(input logic [DIM_W-1:0] span);
        int v;
        v = int'($urandom_range(0, (int'(span) + 8) * 256)) - 1024;
        return v;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'hFFFF_FF80;
        endcase
    endfunction

    function automatic reg_image_t random_setting();
        reg_image_t       r;
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        sw = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(4, 64));
        sh = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(4, 64));
        r[CFG_OUT_WIDTH]    = pad_size(rand_out_dim());
        r[CFG_OUT_HEIGHT]   = pad_size(rand_out_dim());
        r[CFG_SCENE_WIDTH]  = pad_size(sw);
        r[CFG_SCENE_HEIGHT] = pad_size(sh);
        for (cfg_index_t c = CFG_TOP_LEFT; c <= CFG_BOTTOM_LEFT; c = c.next())
        begin
            case ($urandom_range(0, 9))
                0:       r[c] = {$urandom, $urandom};
                1:       r[c] = corner(pick_extreme(), pick_extreme());
                default: r[c] = corner(rand_coord(sw), rand_coord(sh));
            endcase
        end
        return r;
    endfunction

    task automatic send_request(input logic start_frame);
        int gap;
        in_valid    <= 1'b1;
        frame_start <= start_frame;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid    <= 1'b0;
                frame_start <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // everything answered, then give the divider time to go quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_seen != requests_sent)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input reg_image_t regs);
        cfg_index_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= regs[idx];
            @(posedge clk);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
    endtask

    // new corner registers only count from a frame start, so each phase opens with one
    task automatic run_phase(input reg_image_t regs, input int count, input int restart_at,
                             input logic stray_restarts);
        wait_idle();
        load_setting(regs);
        for (int k = 0; k < count; k++)
        begin
            send_request(k == 0 || k == restart_at ||
                         (stray_restarts && $urandom_range(0, 39) == 0));
        end
    endtask

    initial
    begin
        int count;
        int random_sent;
        random_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: frames begin on their own after reset and after frame_done
        repeat (5) send_request(1'b0);

        // quad well inside the scene, restarted mid-frame
        run_phase(pack_setting(corner(384, 576), corner(2496, 512), corner(2560, 1920),
                               corner(128, 2048), 3, 2, 16, 16), 7, 4, 1'b0);
        // extreme corners wrap the accumulators, width clamps up, height clamps down
        run_phase(pack_setting(corner(32'h7FFF_FFFF, 32'h8000_0000),
                               corner(32'h8000_0000, 32'h7FFF_FFFF),
                               corner(32'h7FFF_FFFF, 32'h7FFF_FFFF),
                               corner(32'h8000_0000, 32'h8000_0000),
                               0, 'h1FFF, MAX_DIM, MAX_DIM), 4, -1, 1'b0);
        // small negative positions truncate to address zero
        run_phase(pack_setting(corner(-128, -192), corner(-64, 768), corner(512, 512),
                               corner(-255, 256), 1, 2, 4, 4), 4, -1, 1'b0);
        // zero scene width puts every pixel outside
        run_phase(pack_setting(corner(256, 256), corner(1024, 256), corner(1024, 1024),
                               corner(256, 1024), MAX_DIM + 1, 3, 0, 5), 3, -1, 1'b0);

        while (random_sent < RANDOM_ITEMS)
        begin
            count = $urandom_range(40, 140);
            run_phase(random_setting(), count, -1, 1'b1);
            random_sent += count;
        end

        wait_idle();
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/qtrwa_pkg.sv
rtl/qtrwa_front.sv
rtl/qtrwa_queue.sv
rtl/qtrwa_div.sv
rtl/qtrwa_back.sv
rtl/quad_to_rect_warp_address.sv
dv/warp_address_checker.sv
dv/tb_quad_to_rect_warp_address.sv
